// ----- hdl/client_mac_table_with_aging_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef CLIENT_MAC_TABLE_WITH_AGING_UNIT_DEFINES_SVH
`define CLIENT_MAC_TABLE_WITH_AGING_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CMT_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define CMT_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/cmt_pkg.sv -----
// ----------------------------------------------------------------------------
// cmt_pkg
// types, codes and sizes shared by the client mac table blocks
// ----------------------------------------------------------------------------
package cmt_pkg;

  localparam int ENTRIES    = 32;
  localparam int PORT_COUNT = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam logic [30:0] TTL_RESET = 31'd60;

  localparam logic [2:0] CMD_CREATE     = 3'd0;
  localparam logic [2:0] CMD_UPDATE     = 3'd1;
  localparam logic [2:0] CMD_REFRESH    = 3'd2;
  localparam logic [2:0] CMD_CLEAR      = 3'd3;
  localparam logic [2:0] CMD_FLUSH_ALL  = 3'd4;
  localparam logic [2:0] CMD_FLUSH_PORT = 3'd5;
  localparam logic [2:0] CMD_TICK       = 3'd6;
  localparam logic [2:0] CMD_READ       = 3'd7;

  localparam logic [2:0] EV_DONE    = 3'd0;
  localparam logic [2:0] EV_ADDED   = 3'd1;
  localparam logic [2:0] EV_DELETED = 3'd2;
  localparam logic [2:0] EV_IPCHG   = 3'd3;
  localparam logic [2:0] EV_FULL    = 3'd4;
  localparam logic [2:0] EV_DATA    = 3'd5;
  localparam logic [2:0] EV_EMPTY   = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [47:0] mac_address;
    logic [31:0] ipv4_address;
    logic [3:0]  port_id;
    logic [31:0] rx_add;
    logic [31:0] tx_add;
    logic        alive;
    logic [4:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [47:0] event_mac;
    logic [31:0] event_ipv4;
    logic [3:0]  event_port;
    logic [63:0] rx_total;
    logic [63:0] tx_total;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ipv4;
    logic [3:0]  port;
    logic [31:0] last_seen;
    logic [63:0] rx_total;
    logic [63:0] tx_total;
  } slot_t;

  typedef enum logic [3:0] {
    OP_CREATE, OP_UPDATE, OP_REFRESH, OP_CLEAR, OP_FLUSH_ALL,
    OP_FLUSH_PORT, OP_TICK, OP_READ, OP_SKIP
  } op_t;

  typedef struct packed {
    op_t  op;
    req_t req;
  } work_t;

  function automatic op_t classify(req_t r);
    op_t o;
    case (r.command)
      CMD_CREATE:     o = (32'(r.port_id) >= 32'(PORT_COUNT)) ? OP_SKIP : OP_CREATE;
      CMD_UPDATE:     o = OP_UPDATE;
      CMD_REFRESH:    o = OP_REFRESH;
      CMD_CLEAR:      o = OP_CLEAR;
      CMD_FLUSH_ALL:  o = OP_FLUSH_ALL;
      CMD_FLUSH_PORT: o = OP_FLUSH_PORT;
      CMD_TICK:       o = OP_TICK;
      CMD_READ:       o = OP_READ;
      default:        o = OP_SKIP;
    endcase
    return o;
  endfunction

  function automatic rsp_t mk_rsp(logic [2:0] kind, slot_t s, logic last);
    rsp_t r;
    r.event_kind = kind;
    r.event_mac  = s.mac;
    r.event_ipv4 = s.ipv4;
    r.event_port = s.port;
    r.rx_total   = s.rx_total;
    r.tx_total   = s.tx_total;
    r.last       = last;
    return r;
  endfunction

endpackage

// ----- hdl/cmt_ram.sv -----
// ----------------------------------------------------------------------------
// cmt_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cmt_front.sv -----
// ----------------------------------------------------------------------------
// cmt_front
// takes requests, classifies them and queues them for the sequencer
// ----------------------------------------------------------------------------
module cmt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          request_valid,
  output logic          request_ready,
  input  cmt_pkg::req_t request,
  output logic          work_valid,
  input  logic          work_ready,
  output cmt_pkg::work_t work
);

  cmt_pkg::work_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign request_ready = (count != 2'd2);
  assign work_valid    = (count != 2'd0);
  assign work          = q[rd_ptr];
  assign push          = request_valid && request_ready;
  assign pop           = work_valid && work_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: cmt_pkg::classify(request), req: request};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hdl/cmt_back.sv -----
// ----------------------------------------------------------------------------
// cmt_back
// table sequencer: slot scans, entry updates, ageing and result register
// ----------------------------------------------------------------------------
module cmt_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           work_valid,
  output logic           work_ready,
  input  cmt_pkg::work_t work,
  input  logic           cfg_valid,
  input  logic [30:0]    cfg_ttl_ticks,
  output logic           result_valid,
  input  logic           result_ready,
  output cmt_pkg::rsp_t  result
);

  localparam int IW = cmt_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_ACT, S_SECOND, S_SWEEP, S_FIN, S_READ
  } state_t;

  state_t                 state;
  cmt_pkg::work_t         cur;
  logic [IW-1:0]          scan;
  logic [cmt_pkg::ENTRIES-1:0] valid_bits;
  logic [31:0]            cur_time;
  logic [30:0]            ttl;
  logic                   hit;
  logic [IW-1:0]          hit_slot;
  logic                   free_found;
  logic [IW-1:0]          free_slot;
  cmt_pkg::slot_t         hold;
  logic                   pend_valid;
  cmt_pkg::rsp_t          pend;
  cmt_pkg::rsp_t          second;
  cmt_pkg::rsp_t          fin_rsp;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  cmt_pkg::slot_t         ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [$bits(cmt_pkg::slot_t)-1:0] ram_rdata;
  cmt_pkg::slot_t         rd;

  logic                   can_emit;
  logic                   emit;
  logic                   last_slot;
  logic                   match;
  logic [31:0]            limit;
  logic [31:0]            age_diff;
  logic                   expired;
  logic                   kill;
  logic                   sweep_adv;
  logic                   advance;
  logic                   rd_in_range;
  logic                   rd_hit;

  // results and writes of the action step
  cmt_pkg::slot_t         act_entry;
  logic                   act_we;
  logic [IW-1:0]          act_waddr;
  cmt_pkg::rsp_t          act_rsp;
  logic                   act_two;
  logic                   act_set_valid;

  cmt_ram #(.WIDTH($bits(cmt_pkg::slot_t)), .DEPTH(cmt_pkg::ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd         = cmt_pkg::slot_t'(ram_rdata);
  assign work_ready = (state == S_IDLE);
  assign can_emit   = !result_valid || result_ready;
  assign last_slot  = (scan == IW'(cmt_pkg::ENTRIES - 1));
  assign match      = valid_bits[scan] && (rd.mac == cur.req.mac_address);
  assign limit      = rd.last_seen + {1'b0, ttl};
  assign age_diff   = cur_time - limit;
  assign expired    = (age_diff != 32'd0) && !age_diff[31];
  assign rd_in_range = (32'(cur.req.entry_index) < 32'(cmt_pkg::ENTRIES));
  assign rd_hit     = rd_in_range && valid_bits[IW'(cur.req.entry_index)];

  always_comb begin
    kill = 1'b0;
    if (valid_bits[scan]) begin
      case (cur.op)
        cmt_pkg::OP_FLUSH_ALL:  kill = 1'b1;
        cmt_pkg::OP_FLUSH_PORT: kill = (rd.port == cur.req.port_id);
        cmt_pkg::OP_TICK:       kill = expired;
        default:                kill = 1'b0;
      endcase
    end
  end

  assign sweep_adv = (state == S_SWEEP) && (!kill || !pend_valid || can_emit);
  assign advance   = (state == S_LOOK) || sweep_adv;

  // a new result is loaded this cycle
  assign emit = (can_emit && (state == S_ACT || state == S_SECOND ||
                              state == S_FIN || state == S_READ)) ||
                (sweep_adv && kill && pend_valid);

  // final result of a sweep: the held deletion, or done
  always_comb begin
    fin_rsp      = pend_valid ? pend : cmt_pkg::mk_rsp(cmt_pkg::EV_DONE, '0, 1'b0);
    fin_rsp.last = 1'b1;
  end

  // action step: decided from the held entry once the lookup is over
  always_comb begin
    act_entry     = hold;
    act_we        = 1'b0;
    act_waddr     = hit_slot;
    act_two       = 1'b0;
    act_set_valid = 1'b0;
    act_rsp       = cmt_pkg::mk_rsp(cmt_pkg::EV_DONE, '0, 1'b1);
    case (cur.op)
      cmt_pkg::OP_CREATE: begin
        act_entry = '{mac: cur.req.mac_address, ipv4: cur.req.ipv4_address,
                      port: cur.req.port_id, last_seen: cur_time,
                      rx_total: 64'd0, tx_total: 64'd0};
        if (hit) begin
          if (hold.port != cur.req.port_id) begin
            act_we  = 1'b1;
            act_two = 1'b1;
            act_rsp = cmt_pkg::mk_rsp(cmt_pkg::EV_ADDED, act_entry, 1'b0);
          end
        end else if (free_found) begin
          act_we        = 1'b1;
          act_waddr     = free_slot;
          act_set_valid = 1'b1;
          act_rsp       = cmt_pkg::mk_rsp(cmt_pkg::EV_ADDED, act_entry, 1'b1);
        end else begin
          act_rsp = cmt_pkg::mk_rsp(cmt_pkg::EV_FULL, act_entry, 1'b1);
          act_rsp.rx_total = 64'd0;
          act_rsp.tx_total = 64'd0;
        end
      end
      cmt_pkg::OP_UPDATE, cmt_pkg::OP_REFRESH: begin
        act_entry.rx_total = hold.rx_total + 64'(cur.req.rx_add);
        act_entry.tx_total = hold.tx_total + 64'(cur.req.tx_add);
        if (cur.op == cmt_pkg::OP_REFRESH || cur.req.alive) begin
          act_entry.last_seen = cur_time;
        end
        // an unknown mac reports nothing but done
        if (hit && cur.op == cmt_pkg::OP_UPDATE && cur.req.ipv4_address != 32'd0 &&
            cur.req.ipv4_address != hold.ipv4) begin
          act_entry.ipv4 = cur.req.ipv4_address;
          act_rsp = cmt_pkg::mk_rsp(cmt_pkg::EV_IPCHG, act_entry, 1'b1);
        end
        act_we = hit;
      end
      default: act_we = 1'b0;
    endcase
  end

  // ram port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan;
    ram_wdata = '{mac: rd.mac, ipv4: rd.ipv4, port: rd.port,
                  last_seen: cur_time, rx_total: 64'd0, tx_total: 64'd0};
    case (state)
      S_IDLE: ram_raddr = (work_valid && work.op == cmt_pkg::OP_READ) ?
                          IW'(work.req.entry_index) : '0;
      S_READ: ram_raddr = IW'(cur.req.entry_index);
      default: ram_raddr = advance ? scan + 1'b1 : scan;
    endcase
    if (state == S_SWEEP && sweep_adv && cur.op == cmt_pkg::OP_CLEAR &&
        valid_bits[scan]) begin
      ram_we = 1'b1;
    end
    if (state == S_ACT && can_emit && act_we) begin
      ram_we    = 1'b1;
      ram_waddr = act_waddr;
      ram_wdata = act_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      valid_bits   <= '0;
      cur_time     <= 32'd0;
      ttl          <= cmt_pkg::TTL_RESET;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      hit          <= 1'b0;
      free_found   <= 1'b0;
      scan         <= '0;
    end else begin
      if (cfg_valid && cfg_ttl_ticks != 31'd0) ttl <= cfg_ttl_ticks;
      if (result_ready && !emit) result_valid <= 1'b0;
      if (advance) scan <= scan + 1'b1;
      case (state)
        S_IDLE: begin
          if (work_valid) begin
            cur        <= work;
            scan       <= '0;
            hit        <= 1'b0;
            free_found <= 1'b0;
            pend_valid <= 1'b0;
            case (work.op)
              cmt_pkg::OP_CREATE, cmt_pkg::OP_UPDATE,
              cmt_pkg::OP_REFRESH: state <= S_LOOK;
              cmt_pkg::OP_CLEAR, cmt_pkg::OP_FLUSH_ALL,
              cmt_pkg::OP_FLUSH_PORT: state <= S_SWEEP;
              cmt_pkg::OP_TICK: begin
                cur_time <= cur_time + 32'd1;
                state    <= S_SWEEP;
              end
              cmt_pkg::OP_READ: state <= S_READ;
              default: state <= S_FIN;
            endcase
          end
        end
        S_LOOK: begin
          if (match) begin
            hit      <= 1'b1;
            hit_slot <= scan;
            hold     <= rd;
            state    <= S_ACT;
          end else begin
            if (!valid_bits[scan] && !free_found) begin
              free_found <= 1'b1;
              free_slot  <= scan;
            end
            if (last_slot) state <= S_ACT;
          end
        end
        S_ACT: begin
          if (can_emit) begin
            result_valid <= 1'b1;
            result       <= act_rsp;
            second       <= cmt_pkg::mk_rsp(cmt_pkg::EV_DELETED, hold, 1'b1);
            if (act_set_valid) valid_bits[act_waddr] <= 1'b1;
            state <= act_two ? S_SECOND : S_IDLE;
          end
        end
        S_SECOND: begin
          if (can_emit) begin
            result_valid <= 1'b1;
            result       <= second;
            state        <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (sweep_adv) begin
            if (kill) begin
              valid_bits[scan] <= 1'b0;
              pend_valid       <= 1'b1;
              pend <= cmt_pkg::mk_rsp(cmt_pkg::EV_DELETED, rd, 1'b0);
              // the previous deletion is now known not to be the final one
              if (pend_valid) begin
                result_valid <= 1'b1;
                result       <= pend;
              end
            end
            if (last_slot) state <= S_FIN;
          end
        end
        S_FIN: begin
          if (can_emit) begin
            result_valid <= 1'b1;
            result       <= fin_rsp;
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        S_READ: begin
          if (can_emit) begin
            result_valid <= 1'b1;
            result <= rd_hit ? cmt_pkg::mk_rsp(cmt_pkg::EV_DATA, rd, 1'b1)
                             : cmt_pkg::mk_rsp(cmt_pkg::EV_EMPTY, '0, 1'b1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/client_mac_table_with_aging_unit.sv -----
// ----------------------------------------------------------------------------
// client_mac_table_with_aging_unit
// client mac learning table with per-entry byte totals and tick-based ageing
// ----------------------------------------------------------------------------
// One request is worked at a time. Create, update and refresh scan the 32
// slots of the table RAM one slot a cycle until the MAC is found; clear,
// flush and tick always sweep all 32 slots, stalling while the result side
// is not ready for a held deletion. Read fetches a single slot. The scan
// speed is set by the single read port of the table RAM. A two-deep
// request queue and the result register let both sides run ahead by a
// request. Slot valid bits live in flip-flops, so no clearing pass follows
// reset. The ttl register may be written at any time the block is idle; a
// write of zero is dropped.
module client_mac_table_with_aging_unit (
  input  logic          clk,
  input  logic          rst,
  // request channel
  input  logic          request_valid,
  output logic          request_ready,
  input  cmt_pkg::req_t request,
  // result channel
  output logic          result_valid,
  input  logic          result_ready,
  output cmt_pkg::rsp_t result,
  // ttl register write
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [30:0]   cfg_ttl_ticks
);

  // classified requests waiting for the sequencer
  logic           work_valid;
  logic           work_ready;
  cmt_pkg::work_t work;

  // register writes never stall
  assign cfg_ready = 1'b1;

  cmt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .request       (request),
    .work_valid    (work_valid),
    .work_ready    (work_ready),
    .work          (work)
  );

  // sequencer owns the table, the time counter and the result register
  cmt_back u_back (
    .clk           (clk),
    .rst           (rst),
    .work_valid    (work_valid),
    .work_ready    (work_ready),
    .work          (work),
    .cfg_valid     (cfg_valid),
    .cfg_ttl_ticks (cfg_ttl_ticks),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .result        (result)
  );

endmodule

// ----- hdl/cmt_checker.sv -----
// ----------------------------------------------------------------------------
// cmt_checker
// port-level checks on the result channel of the client mac table
// ----------------------------------------------------------------------------
`include "client_mac_table_with_aging_unit_defines.svh"

module cmt_checker (
  input logic          clk,
  input logic          rst,
  input logic          result_valid,
  input logic          result_ready,
  input cmt_pkg::rsp_t result
);

  `CMT_ASSERT_NEXT(a_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result))

  `CMT_ASSERT_IMPL(a_blank, clk, rst, result_valid && (result.event_kind == cmt_pkg::EV_DONE || result.event_kind == cmt_pkg::EV_EMPTY), result.event_mac == 48'd0 && result.rx_total == 64'd0 && result.tx_total == 64'd0)

  `CMT_ASSERT_IMPL(a_done_last, clk, rst, result_valid && result.event_kind == cmt_pkg::EV_DONE, result.last)

  `CMT_ASSERT_IMPL(a_full, clk, rst, result_valid && result.event_kind == cmt_pkg::EV_FULL, result.last && result.rx_total == 64'd0 && result.tx_total == 64'd0)

endmodule

bind client_mac_table_with_aging_unit cmt_checker u_cmt_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
